// ===== rtl/core/sfr_pkg.sv =====
// Shared types, constants and helpers of the stream find-and-replace block.
package sfr_pkg;

   localparam int unsigned PATTERN_MAX     = 8;
   localparam int unsigned REPLACEMENT_MAX = 8;
   localparam int unsigned WIN_W           = 8 * PATTERN_MAX;
   localparam int unsigned HOLD_W          = WIN_W - 8;
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 4'd3;

   // Configuration as seen by the datapath, lengths already clamped.
   typedef struct packed {
      logic [WIN_W-1:0] pattern;
      logic [3:0]       plen;
      logic [WIN_W-1:0] repl;
      logic [3:0]       rlen;
   } cfg_type;

   // One queued job: window bytes to release, then the replacement on a hit.
   typedef struct packed {
      logic [WIN_W-1:0] window;
      logic [3:0]       win_cnt;
      logic             hit;
      logic             last;
   } job_type;

   function automatic logic [WIN_W-1:0] byte_mask(input logic [3:0] nbytes);
      logic [WIN_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (4'(i) < nbytes) begin
            mask[8*i +: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

endpackage

// ===== rtl/core/sfr_csr.sv =====
// Configuration registers of the find-and-replace block, with length clamping.
module sfr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output sfr_pkg::cfg_type               cfg
);

   logic [sfr_pkg::WIN_W-1:0] pattern_ff;
   logic [3:0]                plen_ff;
   logic [sfr_pkg::WIN_W-1:0] repl_ff;
   logic [3:0]                rlen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= 4'd1;
         repl_ff    <= '0;
         rlen_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sfr_pkg::CSR_PATTERN_BYTES:      pattern_ff <= csr_wr_data;
            sfr_pkg::CSR_PATTERN_LENGTH:     plen_ff    <= csr_wr_data[3:0];
            sfr_pkg::CSR_REPLACEMENT_BYTES:  repl_ff    <= csr_wr_data;
            sfr_pkg::CSR_REPLACEMENT_LENGTH: rlen_ff    <= csr_wr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.pattern = pattern_ff;
      cfg.repl    = repl_ff;
      if (plen_ff == 4'd0) begin
         cfg.plen = 4'd1;
      end else if (plen_ff > 4'(sfr_pkg::PATTERN_MAX)) begin
         cfg.plen = 4'(sfr_pkg::PATTERN_MAX);
      end else begin
         cfg.plen = plen_ff;
      end
      if (rlen_ff > 4'(sfr_pkg::REPLACEMENT_MAX)) begin
         cfg.rlen = 4'(sfr_pkg::REPLACEMENT_MAX);
      end else begin
         cfg.rlen = rlen_ff;
      end
   end

endmodule

// ===== rtl/core/sfr_front.sv =====
// Front end: holds the byte window, compares it with the pattern and issues jobs.
module sfr_front (
   input  logic             clock,
   input  logic             reset,
   input  sfr_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_end_of_text,
   input  logic             queue_full,
   output logic             push,
   output sfr_pkg::job_type job
);

   logic [sfr_pkg::HOLD_W-1:0] window_ff, window_in;
   logic [2:0]                 count_ff, count_in;

   logic                       accept;
   logic [sfr_pkg::WIN_W-1:0]  appended;
   logic [sfr_pkg::WIN_W-1:0]  aligned;
   logic [sfr_pkg::WIN_W-1:0]  remaining;
   logic [3:0]                 count_new;
   logic [3:0]                 n_rel;
   logic [3:0]                 win_cnt;
   logic                       cmp_en;
   logic                       hit;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      appended  = {8'd0, window_ff}
                | (sfr_pkg::WIN_W'(req_in_byte) << {count_ff, 3'b000});
      count_new = {1'b0, count_ff} + 4'd1;
      // Bytes beyond a shortened pattern are released before the compare.
      n_rel     = (count_new > cfg.plen) ? (count_new - cfg.plen) : 4'd0;
      cmp_en    = (count_new >= cfg.plen);
      aligned   = appended >> {n_rel[2:0], 3'b000};
      hit       = cmp_en
               && (((aligned ^ cfg.pattern) & sfr_pkg::byte_mask(cfg.plen)) == '0);

      if (hit) begin
         win_cnt = n_rel;
      end else if (req_end_of_text) begin
         win_cnt = count_new;
      end else if (cmp_en) begin
         win_cnt = n_rel + 4'd1;
      end else begin
         win_cnt = 4'd0;
      end

      remaining = (win_cnt[3]) ? '0 : (appended >> {win_cnt[2:0], 3'b000});

      if (hit || req_end_of_text) begin
         window_in = '0;
         count_in  = '0;
      end else begin
         window_in = remaining[sfr_pkg::HOLD_W-1:0];
         count_in  = 3'(count_new - win_cnt);
      end

      job.window  = appended;
      job.win_cnt = win_cnt;
      job.hit     = hit;
      job.last    = req_end_of_text;

      // Items that produce nothing mid-text never reach the queue.
      push = accept && (req_end_of_text || (win_cnt != 4'd0)
                        || (hit && (cfg.rlen != 4'd0)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         window_ff <= window_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/sfr_queue.sv =====
// Short job queue between the front end and the emitter.
module sfr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfr_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output sfr_pkg::job_type head_job
);

   sfr_pkg::job_type              entry_ff [sfr_pkg::QUEUE_DEPTH];
   logic [sfr_pkg::QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [sfr_pkg::QCNT_W-1:0]    fill_ff, fill_in;

   assign full       = (fill_ff == sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/sfr_back.sv =====
// Back end: walks one job a byte per cycle into the output register, unless the output stalls.
module sfr_back (
   input  logic             clock,
   input  logic             reset,
   input  sfr_pkg::cfg_type cfg,
   input  logic             head_valid,
   input  sfr_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last_of_run,
   output logic             rsp_text_done
);

   logic [3:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       bvalid_ff, last_ff, done_ff;

   logic [4:0] total_wide;
   logic [3:0] total;
   logic       bare;
   logic       final_res;
   logic       load;
   logic [3:0] repl_idx;
   logic [7:0] res_byte;

   always_comb begin
      total_wide = {1'b0, head_job.win_cnt} + ((head_job.hit) ? {1'b0, cfg.rlen} : 5'd0);
      total      = total_wide[3:0];
      bare       = (total == 4'd0);
      final_res  = bare || (idx_ff == (total - 4'd1));
      load       = head_valid && (!valid_ff || rsp_ready);
      pop        = load && final_res;
      idx_in     = final_res ? 4'd0 : (idx_ff + 4'd1);
      repl_idx   = idx_ff - head_job.win_cnt;
      if (bare) begin
         res_byte = 8'd0;
      end else if (idx_ff < head_job.win_cnt) begin
         res_byte = head_job.window[{idx_ff[2:0], 3'b000} +: 8];
      end else begin
         res_byte = cfg.repl[{repl_idx[2:0], 3'b000} +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= res_byte;
         bvalid_ff <= !bare;
         last_ff   <= final_res;
         done_ff   <= final_res && head_job.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_text_done   = done_ff;

endmodule

// ===== rtl/core/stream_find_replace.sv =====
// Top level of the streaming find-and-replace block.
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_ready  req_in_byte, req_end_of_text
//  rsp      out        rsp_valid/rsp_ready  rsp_out_byte, rsp_byte_valid,
//                                           rsp_last_of_run, rsp_text_done
//  csr      in         csr_wr_en            csr_index, csr_wr_data
//
// The front end takes one item per cycle while the queue is not full; results
// pass through the job queue and the output register, one result per cycle
// unless the output stalls; items that emit nothing skip the emitter entirely.
// A four-entry job queue lets the front keep accepting while the emitter works
// or the output stalls; req_ready falls only when that queue is full.
// Reset is synchronous and clears the window, queue and output valid.
module stream_find_replace (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_in_byte,
   input  logic                            req_end_of_text,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_last_of_run,
   output logic                            rsp_text_done,
   input  logic                            csr_wr_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   sfr_pkg::cfg_type cfg;
   sfr_pkg::job_type push_job, head_job;
   logic             push, pop, queue_full, head_valid;

   sfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   sfr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .queue_full      (queue_full),
      .push            (push),
      .job             (push_job)
   );

   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sfr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_text_done   (rsp_text_done)
   );

endmodule

// ===== rtl/core/sfr_checker.sv =====
// Port-level checks of the find-and-replace block, bound to its top level.
module sfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [7:0]                      req_in_byte,
   input logic                            req_end_of_text,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_out_byte,
   input logic                            rsp_byte_valid,
   input logic                            rsp_last_of_run,
   input logic                            rsp_text_done
);

   // A waiting input item keeps its valid and its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_byte)
         && $stable(req_end_of_text))
      else $error("req payload changed while waiting");

   // A stalled result keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_last_of_run)
         && $stable(rsp_text_done))
      else $error("rsp payload changed while stalled");

   // The end of the text always closes the run of its item.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_done |-> rsp_last_of_run)
      else $error("text_done without last_of_run");

   // A bare end marker carries a zero byte and ends the text.
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_text_done && rsp_last_of_run
         && (rsp_out_byte == 8'd0))
      else $error("malformed end marker");

   // No result is shown in the cycle after reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_in_byte     (req_in_byte),
   .req_end_of_text (req_end_of_text),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_text_done   (rsp_text_done)
);
